// ===== rtl/cpfd_pkg.sv =====
package cpfd_pkg;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int LEN_W   = 8;

  // Day counts are taken on year + YEAR_BIAS so that every quotient is of a
  // non-negative value; the bias adds the same amount to both dates.
  localparam int YEAR_BIAS = 400;
  localparam int YB_W      = YEAR_W + 1;
  localparam int COUNT_W   = 25;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT, exact for x below 43690
  localparam int RECIP_25    = 41944;
  localparam int RECIP_SHIFT = 20;
  localparam int YQ_W        = YB_W - 2;
  localparam int PROD_W      = YQ_W + 16;
  localparam int Q100_W      = PROD_W - RECIP_SHIFT;

  localparam int DAYS_PER_YEAR = 365;
  localparam int MOFF_W        = 9;

  localparam int WINDOW_EARLY = 19;
  localparam int WINDOW_LATE  = 10;

  // One remainder cell for each bit of the day difference
  localparam int CELL_COUNT = COUNT_W;
  localparam int PIPE_DEPTH = CELL_COUNT + 5;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_START_YEAR   = 3'd1,
    REG_START_MONTH  = 3'd2,
    REG_START_DAY    = 3'd3,
    REG_PERIOD_LEN   = 3'd4,
    REG_CYCLE_LEN    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_PERIOD = 2'd0,
    PHASE_WINDOW = 2'd1,
    PHASE_SAFE   = 2'd2
  } phase_t;

  // Load enables of the three day-count stages
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
  } dc_en_t;

  typedef struct packed {
    logic              dec_year;
    logic [MOFF_W-1:0] offset;
  } month_info_t;

  // March-based month: m' = (month + 9) mod 12, offset = (306*m' + 5) / 10.
  // January and February count toward the previous year.
  function automatic month_info_t month_info(input logic [MONTH_W-1:0] month);
    month_info_t mi;
    mi = '{dec_year: 1'b0, offset: '0};
    case (month)
      4'd0:  mi = '{dec_year: 1'b0, offset: 9'd275};
      4'd1:  mi = '{dec_year: 1'b1, offset: 9'd306};
      4'd2:  mi = '{dec_year: 1'b1, offset: 9'd337};
      4'd3:  mi = '{dec_year: 1'b0, offset: 9'd0};
      4'd4:  mi = '{dec_year: 1'b0, offset: 9'd31};
      4'd5:  mi = '{dec_year: 1'b0, offset: 9'd61};
      4'd6:  mi = '{dec_year: 1'b0, offset: 9'd92};
      4'd7:  mi = '{dec_year: 1'b0, offset: 9'd122};
      4'd8:  mi = '{dec_year: 1'b0, offset: 9'd153};
      4'd9:  mi = '{dec_year: 1'b0, offset: 9'd184};
      4'd10: mi = '{dec_year: 1'b0, offset: 9'd214};
      4'd11: mi = '{dec_year: 1'b0, offset: 9'd245};
      4'd12: mi = '{dec_year: 1'b0, offset: 9'd275};
      4'd13: mi = '{dec_year: 1'b1, offset: 9'd306};
      4'd14: mi = '{dec_year: 1'b1, offset: 9'd337};
      4'd15: mi = '{dec_year: 1'b0, offset: 9'd0};
      default: mi = '{dec_year: 1'b0, offset: '0};
    endcase
    return mi;
  endfunction

endpackage

// ===== rtl/cpfd_day_count.sv =====
module cpfd_day_count (
  input  logic                            clk,
  input  cpfd_pkg::dc_en_t                en,
  input  logic [cpfd_pkg::YEAR_W-1:0]     year,
  input  logic [cpfd_pkg::MONTH_W-1:0]    month,
  input  logic [cpfd_pkg::DAY_W-1:0]      day,
  output logic [cpfd_pkg::COUNT_W-1:0]    count
);
  import cpfd_pkg::*;

  month_info_t       mi;
  logic [YB_W-1:0]   yb_a;
  logic [MOFF_W-1:0] moff_a;
  logic [DAY_W-1:0]  day_a;
  logic [YQ_W-1:0]   yq;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_b;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] base_b;
  logic [Q100_W-1:0] q100;

  assign mi = month_info(month);

  // Stage 1: biased March-based year and month offset
  always_ff @(posedge clk) begin
    if (en.s0) begin
      yb_a   <= YB_W'({1'b0, year}) + YB_W'(YEAR_BIAS) - YB_W'(mi.dec_year);
      moff_a <= mi.offset;
      day_a  <= day;
    end
  end

  // Stage 2: floor(Y/100) by reciprocal of 25 on Y/4, linear terms alongside
  assign yq   = yb_a[YB_W-1:2];
  assign prod = PROD_W'(yq) * PROD_W'(RECIP_25);
  assign base = COUNT_W'(yb_a) * COUNT_W'(DAYS_PER_YEAR) + COUNT_W'(yq)
              + COUNT_W'(moff_a) + COUNT_W'(day_a);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_b <= prod;
      base_b <= base;
    end
  end

  // Stage 3: Y/400 is (Y/100)/4
  assign q100 = prod_b[PROD_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      count <= base_b - COUNT_W'(q100) + COUNT_W'(q100[Q100_W-1:2]);
    end
  end

endmodule

// ===== rtl/cpfd_mod_cell.sv =====
module cpfd_mod_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cpfd_pkg::LEN_W-1:0]    divisor,
  input  logic [cpfd_pkg::LEN_W-1:0]    rem_in,
  input  logic [cpfd_pkg::COUNT_W-1:0]  dvd_in,
  input  logic                          live_in,
  output logic [cpfd_pkg::LEN_W-1:0]    rem,
  output logic [cpfd_pkg::COUNT_W-1:0]  dvd,
  output logic                          live
);
  import cpfd_pkg::*;

  logic [LEN_W:0] trial;
  logic [LEN_W:0] diff;

  // Bring in the next dividend bit and subtract the divisor when it fits
  assign trial = {rem_in, dvd_in[COUNT_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= (trial >= {1'b0, divisor}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      dvd  <= {dvd_in[COUNT_W-2:0], 1'b0};
      live <= live_in;
    end
  end

endmodule

// ===== rtl/cycle_phase_from_date.sv =====
// Classifies a civil date by its place in a repeating cycle that began on
// the configured start date. Both dates become day counts, the start count
// is subtracted, and the difference is reduced modulo cycle_length by a
// chain of 25 remainder cells, one dividend bit per cell. One item is taken
// each cycle while in_stall is low; an accepted item enters the first of 30
// register stages (3 day-count stages, one subtract stage, 25 cells, one
// output register) and moves through them in that order. Stalls collapse
// empty stages, so new items keep entering while a result waits, until the
// stages are full. cfg_ready is always high.
module cycle_phase_from_date (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cpfd_pkg::YEAR_W-1:0]      current_year,
  input  logic [cpfd_pkg::MONTH_W-1:0]     current_month,
  input  logic [cpfd_pkg::DAY_W-1:0]       current_day,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             result_valid,
  output logic [1:0]                       phase,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cpfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import cpfd_pkg::*;

  localparam int DIFF_STAGE = 3;
  localparam int CELL_BASE  = 4;
  localparam int OUT_STAGE  = PIPE_DEPTH - 1;

  logic                feature_enable;
  logic [YEAR_W-1:0]   start_year;
  logic [MONTH_W-1:0]  start_month;
  logic [DAY_W-1:0]    start_day;
  logic [LEN_W-1:0]    period_length;
  logic [LEN_W-1:0]    cycle_length;

  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH-1:0] en;
  dc_en_t                dc_en;

  logic [COUNT_W-1:0]  cur_count;
  logic [COUNT_W-1:0]  start_count;
  logic [COUNT_W:0]    day_diff;
  logic [COUNT_W-1:0]  diff_mag;
  logic                diff_live;

  logic [LEN_W-1:0]    rem_q  [CELL_COUNT];
  logic [COUNT_W-1:0]  dvd_q  [CELL_COUNT];
  logic                live_q [CELL_COUNT];

  logic [LEN_W-1:0]    pos;
  logic [LEN_W:0]      pos9;
  logic [LEN_W:0]      cyc9;
  logic                in_period;
  logic                in_window;
  logic                res_ok;
  phase_t              phase_next;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_enable <= 1'b0;
      start_year     <= YEAR_W'(2021);
      start_month    <= MONTH_W'(1);
      start_day      <= DAY_W'(1);
      period_length  <= LEN_W'(5);
      cycle_length   <= LEN_W'(28);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:      feature_enable <= cfg_data[0];
        REG_START_YEAR:  start_year     <= cfg_data[YEAR_W-1:0];
        REG_START_MONTH: start_month    <= cfg_data[MONTH_W-1:0];
        REG_START_DAY:   start_day      <= cfg_data[DAY_W-1:0];
        REG_PERIOD_LEN:  period_length  <= cfg_data[LEN_W-1:0];
        REG_CYCLE_LEN:   cycle_length   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its item moves on
  assign en[OUT_STAGE] = !v[OUT_STAGE] || !out_stall;
  for (genvar k = 0; k < OUT_STAGE; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[OUT_STAGE];

  assign dc_en = '{s0: en[0], s1: en[1], s2: en[2]};

  cpfd_day_count u_cur_count (
    .clk   (clk),
    .en    (dc_en),
    .year  (current_year),
    .month (current_month),
    .day   (current_day),
    .count (cur_count)
  );

  cpfd_day_count u_start_count (
    .clk   (clk),
    .en    (dc_en),
    .year  (start_year),
    .month (start_month),
    .day   (start_day),
    .count (start_count)
  );

  assign day_diff = {1'b0, cur_count} - {1'b0, start_count};

  // Mark the result invalid when the date lies before the start
  always_ff @(posedge clk) begin
    if (en[DIFF_STAGE]) begin
      diff_mag  <= day_diff[COUNT_W-1:0];
      diff_live <= !day_diff[COUNT_W];
    end
  end

  for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
    if (c == 0) begin : g_first
      cpfd_mod_cell u_cell (
        .clk     (clk),
        .en      (en[CELL_BASE]),
        .divisor (cycle_length),
        .rem_in  ('0),
        .dvd_in  (diff_mag),
        .live_in (diff_live),
        .rem     (rem_q[0]),
        .dvd     (dvd_q[0]),
        .live    (live_q[0])
      );
    end else begin : g_rest
      cpfd_mod_cell u_cell (
        .clk     (clk),
        .en      (en[CELL_BASE+c]),
        .divisor (cycle_length),
        .rem_in  (rem_q[c-1]),
        .dvd_in  (dvd_q[c-1]),
        .live_in (live_q[c-1]),
        .rem     (rem_q[c]),
        .dvd     (dvd_q[c]),
        .live    (live_q[c])
      );
    end
  end

  // Classify the position; the window test is cyc-19 <= pos <= cyc-10
  assign pos       = rem_q[CELL_COUNT-1];
  assign pos9      = {1'b0, pos};
  assign cyc9      = {1'b0, cycle_length};
  assign in_period = pos < period_length;
  assign in_window = (pos9 + (LEN_W+1)'(WINDOW_EARLY) >= cyc9)
                  && (pos9 + (LEN_W+1)'(WINDOW_LATE) <= cyc9);
  assign res_ok    = feature_enable && (cycle_length != '0) && live_q[CELL_COUNT-1];

  always_comb begin
    if (!res_ok || in_period) begin
      phase_next = PHASE_PERIOD;
    end else if (in_window) begin
      phase_next = PHASE_WINDOW;
    end else begin
      phase_next = PHASE_SAFE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUT_STAGE]) begin
      result_valid <= res_ok;
      phase        <= phase_next;
    end
  end

  // The input is held back only when a result waits at the output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no waiting result");

  a_invalid_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_valid) |-> (phase == PHASE_PERIOD))
    else $error("invalid result carries a nonzero phase");

  a_valid_needs_cfg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_valid) |-> (feature_enable && (cycle_length != '0)))
    else $error("valid result with feature off or zero cycle");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_valid) |->
      (phase == PHASE_PERIOD || phase == PHASE_WINDOW || phase == PHASE_SAFE))
    else $error("unknown phase code");

endmodule
